// ===== hdl/ocs_pkg.sv =====
// Shared constants and types for the object-to-world coordinate transform.
`default_nettype none
package ocs_pkg;

	localparam int COORD_W = 32;
	localparam int WIDE_W = 64;
	localparam int UNIT_SHIFT = 30;
	localparam int AXIS_LIMIT = 1 << (UNIT_SHIFT - 6);
	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS = 31;
	localparam logic [1:0] OUT_SLOTS = 2'd2;

	typedef logic [2:0][COORD_W-1:0] vec3_t;
	typedef logic [2:0][WIDE_W-1:0] wvec3_t;

	typedef struct packed {
		vec3_t pt;
		logic  bad;
		vec3_t az;
		vec3_t ax;
	} side_t;

	typedef struct packed {
		logic [2:0][30:0] mn;
		logic [2:0]       neg;
		logic             zero;
		side_t            side;
	} norm_ctl_t;

	typedef struct packed {
		vec3_t world;
		logic  bad;
		logic  sat;
	} res_t;

endpackage
`default_nettype wire

// ===== hdl/ocs_norm.sv =====
// Pipelined vector normalizer: scaling, square root and three division lanes.
`default_nettype none
module ocs_norm (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          src_valid,
	input  ocs_pkg::wvec3_t vec,
	input  ocs_pkg::side_t  src_side,
	output logic          dst_valid,
	output ocs_pkg::vec3_t  unit_vec,
	output ocs_pkg::side_t  dst_side
);
	import ocs_pkg::*;

	wvec3_t      mag_c, mag_s1, mag_s2, sh_c;
	logic [63:0] mx_c, mx_s1;
	logic [2:0]  neg_c, neg_s1, neg_s2;
	side_t       side_s1, side_s2;
	logic        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [5:0]  pos_c, pos_s2;
	logic        zero_s2;
	norm_ctl_t   ctl_c, ctl_s3, ctl_s4, ctl_s5;
	logic [2:0][61:0] sq_s4;
	logic [63:0] sum_s5;

	logic [33:0] srem [SQRT_STEPS+1];
	logic [31:0] sroot [SQRT_STEPS+1];
	logic [63:0] srad [SQRT_STEPS+1];
	norm_ctl_t   sctl [SQRT_STEPS+1];
	logic        svld [SQRT_STEPS+1];

	logic [2:0][61:0] num_c;
	logic [2:0][31:0] drem [DIV_STEPS+1];
	logic [2:0][30:0] dlow [DIV_STEPS+1];
	logic [2:0][30:0] dq [DIV_STEPS+1];
	logic [31:0]      dr [DIV_STEPS+1];
	norm_ctl_t        dctl [DIV_STEPS+1];
	logic             dvld [DIV_STEPS+1];

	always_comb begin
		mx_c = '0;
		for (int i = 0; i < 3; i++) begin
			neg_c[i] = vec[i][63];
			mag_c[i] = neg_c[i] ? (64'd0 - vec[i]) : vec[i];
			if (mag_c[i] > mx_c) begin
				mx_c = mag_c[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= mag_c;
			mx_s1 <= mx_c;
			neg_s1 <= neg_c;
			side_s1 <= src_side;
		end
	end

	always_comb begin
		pos_c = '0;
		for (int b = 0; b < 64; b++) begin
			if (mx_s1[b]) begin
				pos_c = 6'(b);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s2 <= pos_c;
			zero_s2 <= (mx_s1 == '0);
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
			side_s2 <= side_s1;
		end
	end

	always_comb begin
		ctl_c.neg = neg_s2;
		ctl_c.zero = zero_s2;
		ctl_c.side = side_s2;
		for (int i = 0; i < 3; i++) begin
			if (pos_s2 > 6'd30) begin
				sh_c[i] = mag_s2[i] >> (pos_s2 - 6'd30);
			end else begin
				sh_c[i] = mag_s2[i] << (6'd30 - pos_s2);
			end
			ctl_c.mn[i] = sh_c[i][30:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s3 <= ctl_c;
			for (int i = 0; i < 3; i++) begin
				sq_s4[i] <= {31'd0, ctl_s3.mn[i]} * {31'd0, ctl_s3.mn[i]};
			end
			ctl_s4 <= ctl_s3;
			sum_s5 <= {2'b00, sq_s4[0]} + {2'b00, sq_s4[1]} + {2'b00, sq_s4[2]};
			ctl_s5 <= ctl_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= src_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	assign srem[0] = '0;
	assign sroot[0] = '0;
	assign srad[0] = sum_s5;
	assign sctl[0] = ctl_s5;
	assign svld[0] = vld_s5;

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		logic [33:0] rem_n, trial;
		always_comb begin
			rem_n = {srem[k][31:0], srad[k][63:62]};
			trial = {sroot[k], 2'b01};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_n >= trial) begin
					srem[k+1] <= rem_n - trial;
					sroot[k+1] <= {sroot[k][30:0], 1'b1};
				end else begin
					srem[k+1] <= rem_n;
					sroot[k+1] <= {sroot[k][30:0], 1'b0};
				end
				srad[k+1] <= {srad[k][61:0], 2'b00};
				sctl[k+1] <= sctl[k];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				svld[k+1] <= 1'b0;
			end else if (en) begin
				svld[k+1] <= svld[k];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num_c[i] = {1'b0, sctl[SQRT_STEPS].mn[i], 30'd0}
				+ {31'd0, sroot[SQRT_STEPS][31:1]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				drem[0][i] <= {1'b0, num_c[i][61:31]};
				dlow[0][i] <= num_c[i][30:0];
				dq[0][i] <= '0;
			end
			dr[0] <= sroot[SQRT_STEPS];
			dctl[0] <= sctl[SQRT_STEPS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvld[0] <= 1'b0;
		end else if (en) begin
			dvld[0] <= svld[SQRT_STEPS];
		end
	end

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		logic [2:0][32:0] rem2;
		logic [2:0]       ge;
		always_comb begin
			for (int i = 0; i < 3; i++) begin
				rem2[i] = {drem[j][i], dlow[j][i][30]};
				ge[i] = (rem2[i] >= {1'b0, dr[j]});
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					if (ge[i]) begin
						drem[j+1][i] <= 32'(rem2[i] - {1'b0, dr[j]});
					end else begin
						drem[j+1][i] <= rem2[i][31:0];
					end
					dq[j+1][i] <= {dq[j][i][29:0], ge[i]};
					dlow[j+1][i] <= {dlow[j][i][29:0], 1'b0};
				end
				dr[j+1] <= dr[j];
				dctl[j+1] <= dctl[j];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvld[j+1] <= 1'b0;
			end else if (en) begin
				dvld[j+1] <= dvld[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (dctl[DIV_STEPS].zero) begin
					unit_vec[i] <= '0;
				end else if (dctl[DIV_STEPS].neg[i]) begin
					unit_vec[i] <= 32'd0 - {1'b0, dq[DIV_STEPS][i]};
				end else begin
					unit_vec[i] <= {1'b0, dq[DIV_STEPS][i]};
				end
			end
			dst_side <= dctl[DIV_STEPS].side;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_valid <= 1'b0;
		end else if (en) begin
			dst_valid <= dvld[DIV_STEPS];
		end
	end

endmodule
`default_nettype wire

// ===== hdl/ocs_mac.sv =====
// Output stage: sum of the axes weighted by point coordinates, rounding and clipping.
`default_nettype none
module ocs_mac (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          src_valid,
	input  ocs_pkg::vec3_t  ay,
	input  ocs_pkg::side_t  src_side,
	output logic          dst_valid,
	output ocs_pkg::res_t   res
);
	import ocs_pkg::*;

	localparam logic signed [65:0] RND = 66'sd1 <<< (UNIT_SHIFT - 1);

	logic signed [63:0] prod_s1 [3][3];
	logic signed [65:0] sum_s2 [3];
	vec3_t pt_s1, pt_s2;
	logic  bad_s1, bad_s2, vld_s1, vld_s2;
	logic [2:0][35:0] v_c;
	logic [2:0]       ovf_c;
	vec3_t            clip_c;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				prod_s1[i][0] <= $signed(src_side.pt[0]) * $signed(src_side.ax[i]);
				prod_s1[i][1] <= $signed(src_side.pt[1]) * $signed(ay[i]);
				prod_s1[i][2] <= $signed(src_side.pt[2]) * $signed(src_side.az[i]);
			end
			pt_s1 <= src_side.pt;
			bad_s1 <= src_side.bad;
			for (int i = 0; i < 3; i++) begin
				sum_s2[i] <= 66'(prod_s1[i][0]) + 66'(prod_s1[i][1])
					+ 66'(prod_s1[i][2]) + RND;
			end
			pt_s2 <= pt_s1;
			bad_s2 <= bad_s1;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			v_c[i] = sum_s2[i][65:30];
			ovf_c[i] = (v_c[i][35:31] != {5{v_c[i][35]}});
			if (ovf_c[i]) begin
				clip_c[i] = v_c[i][35] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
			end else begin
				clip_c[i] = v_c[i][31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res.world <= bad_s2 ? pt_s2 : clip_c;
			res.bad <= bad_s2;
			res.sat <= !bad_s2 && (ovf_c != 3'b000);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			dst_valid <= 1'b0;
		end else if (en) begin
			vld_s1 <= src_valid;
			vld_s2 <= vld_s1;
			dst_valid <= vld_s2;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/ocs_to_wcs_transform_top.sv =====
// Top level of the object-to-world coordinate transform pipeline.
// Three normalizers of 70 stages each (32 square-root steps and 31 division steps dominate),
// plus select, cross-product and output stages. Throughput: one request per cycle, stalling
// only when the two-slot output buffer is full. Reset clears all valid bits and the output
// buffer.
`default_nettype none
module ocs_to_wcs_transform_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [31:0]        dir_x,
	input  logic signed [31:0]        dir_y,
	input  logic signed [31:0]        dir_z,
	input  logic signed [31:0]        point_x,
	input  logic signed [31:0]        point_y,
	input  logic signed [31:0]        point_z,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [31:0]        world_x,
	output logic signed [31:0]        world_y,
	output logic signed [31:0]        world_z,
	output logic                      bad_direction,
	output logic                      saturated
);
	import ocs_pkg::*;

	logic   en;
	vec3_t  dir_s0, pt_s0;
	logic   vld_s0;
	wvec3_t v1_c, v2_c;
	side_t  side1_c;

	logic   n1_valid, n2_valid, n3_valid, mac_valid;
	vec3_t  az_u, ax_u, ay_u;
	side_t  n1_side, n2_side, n3_side;

	vec3_t  t_s1;
	side_t  side_s1, side_s2;
	logic   vld_s1, vld_s2, vld_s3;
	logic   small_c;
	logic signed [63:0] cp_s2 [6];
	wvec3_t tv_s3;
	side_t  side_s3;

	res_t   mac_res;
	res_t   slot_q [2];
	logic [1:0] cnt_q;
	logic   push, pop;

	assign en = (cnt_q != OUT_SLOTS);
	assign in_ready = en;

	always_ff @(posedge clk) begin
		if (en) begin
			dir_s0 <= {dir_z, dir_y, dir_x};
			pt_s0 <= {point_z, point_y, point_x};
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			v1_c[i] = {{32{dir_s0[i][31]}}, dir_s0[i]};
		end
		side1_c.pt = pt_s0;
		side1_c.bad = (dir_s0 == '0);
		side1_c.az = '0;
		side1_c.ax = '0;
	end

	ocs_norm u_norm_z (
		.clk(clk), .arst_n(arst_n), .en(en),
		.src_valid(vld_s0), .vec(v1_c), .src_side(side1_c),
		.dst_valid(n1_valid), .unit_vec(az_u), .dst_side(n1_side)
	);

	always_comb begin
		small_c = ($signed(az_u[0]) < AXIS_LIMIT) && ($signed(az_u[0]) > -AXIS_LIMIT)
			&& ($signed(az_u[1]) < AXIS_LIMIT) && ($signed(az_u[1]) > -AXIS_LIMIT);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (small_c) begin
				t_s1 <= {32'd0 - az_u[0], 32'd0, az_u[2]};
			end else begin
				t_s1 <= {32'd0, az_u[0], 32'd0 - az_u[1]};
			end
			side_s1.pt <= n1_side.pt;
			side_s1.bad <= n1_side.bad;
			side_s1.ax <= n1_side.ax;
			side_s1.az <= az_u;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			v2_c[i] = {{32{t_s1[i][31]}}, t_s1[i]};
		end
	end

	ocs_norm u_norm_x (
		.clk(clk), .arst_n(arst_n), .en(en),
		.src_valid(vld_s1), .vec(v2_c), .src_side(side_s1),
		.dst_valid(n2_valid), .unit_vec(ax_u), .dst_side(n2_side)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			cp_s2[0] <= $signed(n2_side.az[1]) * $signed(ax_u[2]);
			cp_s2[1] <= $signed(n2_side.az[2]) * $signed(ax_u[1]);
			cp_s2[2] <= $signed(n2_side.az[2]) * $signed(ax_u[0]);
			cp_s2[3] <= $signed(n2_side.az[0]) * $signed(ax_u[2]);
			cp_s2[4] <= $signed(n2_side.az[0]) * $signed(ax_u[1]);
			cp_s2[5] <= $signed(n2_side.az[1]) * $signed(ax_u[0]);
			side_s2.pt <= n2_side.pt;
			side_s2.bad <= n2_side.bad;
			side_s2.az <= n2_side.az;
			side_s2.ax <= ax_u;
			tv_s3[0] <= cp_s2[0] - cp_s2[1];
			tv_s3[1] <= cp_s2[2] - cp_s2[3];
			tv_s3[2] <= cp_s2[4] - cp_s2[5];
			side_s3 <= side_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s0 <= in_valid;
			vld_s1 <= n1_valid;
			vld_s2 <= n2_valid;
			vld_s3 <= vld_s2;
		end
	end

	ocs_norm u_norm_y (
		.clk(clk), .arst_n(arst_n), .en(en),
		.src_valid(vld_s3), .vec(tv_s3), .src_side(side_s3),
		.dst_valid(n3_valid), .unit_vec(ay_u), .dst_side(n3_side)
	);

	ocs_mac u_mac (
		.clk(clk), .arst_n(arst_n), .en(en),
		.src_valid(n3_valid), .ay(ay_u), .src_side(n3_side),
		.dst_valid(mac_valid), .res(mac_res)
	);

	assign push = en && mac_valid;
	assign out_valid = (cnt_q != 2'd0);
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push && (cnt_q == 2'd0 || (cnt_q == 2'd1 && pop))) begin
			slot_q[0] <= mac_res;
		end else if (pop) begin
			slot_q[0] <= slot_q[1];
		end
		if (push && cnt_q == 2'd1 && !pop) begin
			slot_q[1] <= mac_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push && !pop) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (pop && !push) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	assign world_x = slot_q[0].world[0];
	assign world_y = slot_q[0].world[1];
	assign world_z = slot_q[0].world[2];
	assign bad_direction = slot_q[0].bad;
	assign saturated = slot_q[0].sat;

endmodule
`default_nettype wire
